// File: rtl/crfs_pkg.sv
`default_nettype none

package crfs_pkg;

    // Default coordinate width, wraps at this many bits
    localparam int COORD_BITS_DEF = 16;

    // Jobs held between the front and the back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Most results one item can cause, and the index that walks them
    localparam int MAX_RESULTS = 12;
    localparam int IDX_BITS    = $clog2(MAX_RESULTS);

    // Input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Result kinds as seen on the result port
    typedef enum logic [1:0] {
        RES_PIXEL = 2'd0,
        RES_SPAN  = 2'd1,
        RES_NOP   = 2'd2
    } t_res_kind;

    // What the back has to do for one accepted item
    typedef enum logic [1:0] {
        JOB_START,
        JOB_STEP,
        JOB_NOP
    } t_job_kind;

    typedef struct packed {
        t_job_kind kind;
        logic      fill;
        logic      done;
    } t_job_ctl;

    localparam int JOB_CTL_BITS = $bits(t_job_ctl);

endpackage

`default_nettype wire

// File: rtl/crfs_front.sv
`default_nettype none

module crfs_front import crfs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_opcode,
    input  wire logic signed [COORD_BITS-1:0] i_center_x,
    input  wire logic signed [COORD_BITS-1:0] i_center_y,
    input  wire logic signed [COORD_BITS-1:0] i_edge_x,
    input  wire logic signed [COORD_BITS-1:0] i_edge_y,
    input  wire logic                         i_fill_enable,
    output t_job_ctl                          o_ctl,
    output logic [COORD_BITS-1:0]             o_cx,
    output logic [COORD_BITS-1:0]             o_cy,
    output logic [COORD_BITS-1:0]             o_x,
    output logic [COORD_BITS-1:0]             o_y
);

    localparam int STEP_BITS = COORD_BITS + 1;
    localparam int DEC_BITS  = COORD_BITS + 5;
    localparam logic [DEC_BITS-1:0] DEC_SEED     = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] DEC_ADD_AXIS = DEC_BITS'(6);
    localparam logic [DEC_BITS-1:0] DEC_ADD_DIAG = DEC_BITS'(10);

    logic [COORD_BITS-1:0] r_cx, n_cx;
    logic [COORD_BITS-1:0] r_cy, n_cy;
    logic [STEP_BITS-1:0]  r_step_x, n_step_x;
    logic [STEP_BITS-1:0]  r_step_y, n_step_y;
    logic [DEC_BITS-1:0]   r_decision, n_decision;
    logic                  r_fill, n_fill;
    logic                  r_active, n_active;

    logic signed [STEP_BITS-1:0] dx, dy;
    logic [STEP_BITS-1:0]        dx_abs, dy_abs, radius;
    logic [DEC_BITS-1:0]         dec_seed;
    logic [STEP_BITS-1:0]        sx_inc, sy_dec, sy_next;
    logic [DEC_BITS-1:0]         diff;
    logic [DEC_BITS-1:0]         dec_next;
    logic                        dec_neg;
    logic                        step_done;

    // Radius from the larger of the two distances
    always_comb begin
        dx = $signed({i_edge_x[COORD_BITS-1], i_edge_x})
           - $signed({i_center_x[COORD_BITS-1], i_center_x});
        dy = $signed({i_edge_y[COORD_BITS-1], i_edge_y})
           - $signed({i_center_y[COORD_BITS-1], i_center_y});
        dx_abs = dx[STEP_BITS-1] ? STEP_BITS'(-dx) : STEP_BITS'(dx);
        dy_abs = dy[STEP_BITS-1] ? STEP_BITS'(-dy) : STEP_BITS'(dy);
        radius = (dy_abs > dx_abs) ? dy_abs : dx_abs;
        dec_seed = DEC_SEED - {3'b000, radius, 1'b0};
    end

    // Advance x, and y when the decision is not negative
    always_comb begin
        dec_neg = r_decision[DEC_BITS-1];
        sx_inc  = r_step_x + STEP_BITS'(1);
        sy_dec  = r_step_y - STEP_BITS'(1);
        sy_next = dec_neg ? r_step_y : sy_dec;
        diff    = {4'b0000, sx_inc} - {4'b0000, sy_dec};
        if (dec_neg) begin
            dec_next = r_decision + {2'b00, sx_inc, 2'b00} + DEC_ADD_AXIS;
        end else begin
            dec_next = r_decision + {diff[DEC_BITS-3:0], 2'b00} + DEC_ADD_DIAG;
        end
        step_done = !(sx_inc < sy_next);
    end

    // Build the job and the next state
    always_comb begin
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_step_x   = r_step_x;
        n_step_y   = r_step_y;
        n_decision = r_decision;
        n_fill     = r_fill;
        n_active   = r_active;
        o_ctl      = '{kind: JOB_NOP, fill: 1'b0, done: 1'b1};
        o_cx       = '0;
        o_cy       = '0;
        o_x        = '0;
        o_y        = '0;
        if (i_opcode == OP_START) begin
            n_cx       = i_center_x;
            n_cy       = i_center_y;
            n_step_x   = '0;
            n_step_y   = radius;
            n_decision = dec_seed;
            n_fill     = i_fill_enable;
            n_active   = (radius != '0);
            o_ctl      = '{kind: JOB_START, fill: i_fill_enable, done: (radius == '0)};
            o_cx       = i_center_x;
            o_cy       = i_center_y;
            o_y        = radius[COORD_BITS-1:0];
        end else if (r_active) begin
            n_step_x   = sx_inc;
            n_step_y   = sy_next;
            n_decision = dec_next;
            n_active   = !step_done;
            o_ctl      = '{kind: JOB_STEP, fill: r_fill, done: step_done};
            o_cx       = r_cx;
            o_cy       = r_cy;
            o_x        = sx_inc[COORD_BITS-1:0];
            o_y        = sy_next[COORD_BITS-1:0];
        end
    end

    // Commit state on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx       <= '0;
            r_cy       <= '0;
            r_step_x   <= '0;
            r_step_y   <= '0;
            r_decision <= '0;
            r_fill     <= 1'b0;
            r_active   <= 1'b0;
        end else if (i_accept) begin
            r_cx       <= n_cx;
            r_cy       <= n_cy;
            r_step_x   <= n_step_x;
            r_step_y   <= n_step_y;
            r_decision <= n_decision;
            r_fill     <= n_fill;
            r_active   <= n_active;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crfs_queue.sv
`default_nettype none

module crfs_queue import crfs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crfs_back.sv
`default_nettype none

module crfs_back import crfs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_job_valid,
    input  wire t_job_ctl              i_ctl,
    input  wire logic [COORD_BITS-1:0] i_cx,
    input  wire logic [COORD_BITS-1:0] i_cy,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    output logic                       o_job_pop,
    input  wire logic                  i_res_pop,
    output logic                       o_res_valid,
    output t_res_kind                  o_kind,
    output logic [COORD_BITS-1:0]      o_pos_x,
    output logic [COORD_BITS-1:0]      o_pos_y,
    output logic [COORD_BITS-1:0]      o_span_end_x,
    output logic                       o_last,
    output logic                       o_done_res
);

    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic                r_valid, n_valid;
    t_res_kind           r_kind, n_kind;
    logic [COORD_BITS-1:0] r_pos_x, n_pos_x;
    logic [COORD_BITS-1:0] r_pos_y, n_pos_y;
    logic [COORD_BITS-1:0] r_end_x, n_end_x;
    logic                r_last, n_last;
    logic                r_done;

    logic                advance;
    logic [IDX_BITS-1:0] slot;
    logic [IDX_BITS-1:0] last_idx;

    // Start items walk a subset of the step slots with x at zero
    always_comb begin
        slot     = r_idx;
        last_idx = '0;
        unique case (i_ctl.kind)
            JOB_START: begin
                last_idx = i_ctl.fill ? IDX_BITS'(4) : IDX_BITS'(3);
                case (r_idx)
                    IDX_BITS'(0): slot = IDX_BITS'(0);
                    IDX_BITS'(1): slot = IDX_BITS'(2);
                    IDX_BITS'(2): slot = IDX_BITS'(4);
                    IDX_BITS'(3): slot = IDX_BITS'(5);
                    default:      slot = IDX_BITS'(10);
                endcase
            end
            JOB_STEP: begin
                last_idx = i_ctl.fill ? IDX_BITS'(MAX_RESULTS - 1) : IDX_BITS'(7);
            end
            default: begin
                last_idx = '0;
            end
        endcase
    end

    // Produce the result for the current slot
    always_comb begin
        n_kind  = RES_PIXEL;
        n_pos_x = i_cx;
        n_pos_y = i_cy;
        n_end_x = i_cx;
        unique case (slot)
            IDX_BITS'(0): begin
                n_pos_x = i_cx + i_x;
                n_pos_y = i_cy + i_y;
            end
            IDX_BITS'(1): begin
                n_pos_x = i_cx - i_x;
                n_pos_y = i_cy + i_y;
            end
            IDX_BITS'(2): begin
                n_pos_x = i_cx + i_x;
                n_pos_y = i_cy - i_y;
            end
            IDX_BITS'(3): begin
                n_pos_x = i_cx - i_x;
                n_pos_y = i_cy - i_y;
            end
            IDX_BITS'(4): begin
                n_pos_x = i_cx + i_y;
                n_pos_y = i_cy + i_x;
            end
            IDX_BITS'(5): begin
                n_pos_x = i_cx - i_y;
                n_pos_y = i_cy + i_x;
            end
            IDX_BITS'(6): begin
                n_pos_x = i_cx + i_y;
                n_pos_y = i_cy - i_x;
            end
            IDX_BITS'(7): begin
                n_pos_x = i_cx - i_y;
                n_pos_y = i_cy - i_x;
            end
            IDX_BITS'(8): begin
                n_kind  = RES_SPAN;
                n_pos_x = i_cx + i_x;
                n_pos_y = i_cy + i_y - ONE;
                n_end_x = i_cx - i_x - ONE;
            end
            IDX_BITS'(9): begin
                n_kind  = RES_SPAN;
                n_pos_x = i_cx + i_x;
                n_pos_y = i_cy - i_y + ONE;
                n_end_x = i_cx - i_x - ONE;
            end
            IDX_BITS'(10): begin
                n_kind  = RES_SPAN;
                n_pos_x = i_cx + i_y - ONE;
                n_pos_y = i_cy + i_x;
                n_end_x = i_cx - i_y;
            end
            default: begin
                n_kind  = RES_SPAN;
                n_pos_x = i_cx + i_y - ONE;
                n_pos_y = i_cy - i_x;
                n_end_x = i_cx - i_y;
            end
        endcase
        // Pixels end where they start
        if (n_kind == RES_PIXEL) begin
            n_end_x = n_pos_x;
        end
        // Idle step gives one empty result
        if (i_ctl.kind == JOB_NOP) begin
            n_kind  = RES_NOP;
            n_pos_x = '0;
            n_pos_y = '0;
            n_end_x = '0;
        end
        n_last = (r_idx == last_idx);
    end

    // Move on when the output register is free or being taken
    always_comb begin
        advance   = i_job_valid && (!r_valid || i_res_pop);
        o_job_pop = advance && n_last;
        n_idx     = r_idx;
        n_valid   = r_valid && !i_res_pop;
        if (advance) begin
            n_valid = 1'b1;
            n_idx   = n_last ? '0 : r_idx + IDX_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind  <= n_kind;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_end_x <= n_end_x;
            r_last  <= n_last;
            r_done  <= i_ctl.done;
        end
    end

    assign o_res_valid  = r_valid;
    assign o_kind       = r_kind;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_span_end_x = r_end_x;
    assign o_last       = r_last;
    assign o_done_res   = r_done;

endmodule

`default_nettype wire

// File: rtl/circle_rasterizer_with_fill_spans_core.sv
`default_nettype none

// Midpoint circle rasteriser, one step per item. A start item (opcode 0)
// takes the centre and an edge point, sets the radius to the larger of
// |dx| and |dy| and gives the four axis pixels, plus a centre span when
// fill is on. Each step item (opcode 1) gives the eight symmetric border
// pixels, plus four fill spans when fill is on; done_res is set on every
// result of the item that finishes the circle, and last marks each item's
// final result. A step with no circle running gives one no-op result.
// Timing: the front takes one item per cycle while the job queue
// (QUEUE_DEPTH entries) has room; the back writes one result per cycle
// into the output register while a job waits and that register is
// empty or being popped; an item gives 4 or 5 results for a start,
// 8 or 12 for a step, 1 for a no-op. Coordinates wrap at COORD_BITS bits.
module circle_rasterizer_with_fill_spans_core import crfs_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         i_opcode,
    input  wire logic signed [COORD_BITS-1:0] i_center_x,
    input  wire logic signed [COORD_BITS-1:0] i_center_y,
    input  wire logic signed [COORD_BITS-1:0] i_edge_x,
    input  wire logic signed [COORD_BITS-1:0] i_edge_y,
    input  wire logic                         i_fill_enable,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [1:0]                        o_kind,
    output logic signed [COORD_BITS-1:0]      o_pos_x,
    output logic signed [COORD_BITS-1:0]      o_pos_y,
    output logic signed [COORD_BITS-1:0]      o_span_end_x,
    output logic                              o_last,
    output logic                              o_done_res
);

    localparam int JOB_BITS = JOB_CTL_BITS + 4 * COORD_BITS;

    logic                  accept;
    t_job_ctl              fr_ctl;
    logic [COORD_BITS-1:0] fr_cx, fr_cy, fr_x, fr_y;
    logic [JOB_BITS-1:0]   q_in, q_out;
    logic                  q_valid, q_pop;
    t_job_ctl              bk_ctl;
    logic [COORD_BITS-1:0] bk_cx, bk_cy, bk_x, bk_y;
    logic                  res_valid;
    t_res_kind             res_kind;

    assign accept = push && !full;

    // Classify items and keep the circle state
    crfs_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_edge_x     (i_edge_x),
        .i_edge_y     (i_edge_y),
        .i_fill_enable(i_fill_enable),
        .o_ctl        (fr_ctl),
        .o_cx         (fr_cx),
        .o_cy         (fr_cy),
        .o_x          (fr_x),
        .o_y          (fr_y)
    );

    assign q_in = {fr_ctl, fr_cx, fr_cy, fr_x, fr_y};

    // Queue jobs between front and back
    crfs_queue #(
        .WIDTH(JOB_BITS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_full (full),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    assign {bk_ctl, bk_cx, bk_cy, bk_x, bk_y} = q_out;

    // Expand each job into its results
    crfs_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_ctl       (bk_ctl),
        .i_cx        (bk_cx),
        .i_cy        (bk_cy),
        .i_x         (bk_x),
        .i_y         (bk_y),
        .o_job_pop   (q_pop),
        .i_res_pop   (pop),
        .o_res_valid (res_valid),
        .o_kind      (res_kind),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_span_end_x(o_span_end_x),
        .o_last      (o_last),
        .o_done_res  (o_done_res)
    );

    assign empty  = !res_valid;
    assign o_kind = res_kind;

endmodule

`default_nettype wire
